/* src/kmst_pkg.sv */
`default_nettype none
package kmst_pkg;

	localparam int VTX_W   = 5;
	localparam int WT_W    = 16;
	localparam int TOT_W   = 21;
	localparam int VCNT_W  = 6;
	// wide enough for an effective vertex count up to the largest parameter value
	localparam int NEFF_W  = 7;

	localparam logic signed [TOT_W:0] TOTAL_MAX = 22'sd1048575;
	localparam logic signed [TOT_W:0] TOTAL_MIN = -22'sd1048576;

	typedef struct packed {
		logic [VTX_W-1:0]       src;
		logic [VTX_W-1:0]       dst;
		logic signed [WT_W-1:0] wt;
	} edge_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SCAN,
		ST_FLUSH
	} state_t;

endpackage
`default_nettype wire

/* src/kruskal_mst_engine.sv */
`default_nettype none
// Kruskal spanning tree engine.
// Input channel (in_valid/in_ready): one edge per transfer with source,
// destination, signed weight and last_edge. Edges are taken one per cycle
// while loading; each is placed in weight order in a row of sorting cells
// as it arrives, so sorting costs no extra time.
// On the transfer with last_edge set the engine scans the sorted row, one
// edge per cycle unless a stalled receiver holds it, through a row of
// per-vertex component labels, and stops after vertex_count-1 accepted
// edges or at the end of the row. The input is not ready again until the
// last result has been loaded into the output register.
// Output channel (out_valid/out_ready): one transfer per accepted edge in
// ascending weight order with a saturating running total, dropped_flag and
// last_result; a graph with no accepted edge yields one empty result.
// A stalled receiver holds the scan when an accepted edge has nowhere to go.
// Configuration: cfg_we writes vertex_count from cfg_wdata.
// Reset clears the store count, drop flag and labels; vertex_count is 32.
module kruskal_mst_engine #(
	parameter int MAX_VERTICES = 32,
	parameter int MAX_EDGES    = 256
) (
	input  wire  logic                                clk,
	input  wire  logic                                arst_n,
	input  wire  logic                                cfg_we,
	input  wire  logic [kmst_pkg::VCNT_W-1:0]         cfg_wdata,
	input  wire  logic                                in_valid,
	output       logic                                in_ready,
	input  wire  logic [kmst_pkg::VTX_W-1:0]          edge_source,
	input  wire  logic [kmst_pkg::VTX_W-1:0]          edge_destination,
	input  wire  logic signed [kmst_pkg::WT_W-1:0]    edge_weight,
	input  wire  logic                                last_edge,
	output       logic                                out_valid,
	input  wire  logic                                out_ready,
	output       logic [kmst_pkg::VTX_W-1:0]          tree_source,
	output       logic [kmst_pkg::VTX_W-1:0]          tree_destination,
	output       logic signed [kmst_pkg::WT_W-1:0]    tree_weight,
	output       logic                                edge_valid,
	output       logic signed [kmst_pkg::TOT_W-1:0]   running_total,
	output       logic                                dropped_flag,
	output       logic                                last_result
);
	import kmst_pkg::*;

	localparam int CW = $clog2(MAX_EDGES + 1);

	state_t state_q, state_d;
	logic [VCNT_W-1:0] vcnt_q;
	logic [CW-1:0] count_q, scan_q;
	logic [NEFF_W-1:0] acc_q;
	logic drop_q;
	logic [NEFF_W-1:0] neff;

	edge_t key;
	edge_t cur [MAX_EDGES];
	logic  gtv [MAX_EDGES];

	edge_t pend_q;
	logic signed [TOT_W-1:0] pend_tot_q, total_q;
	logic pend_v_q;

	logic in_xfer, store_ok, ins, shift, done, accept, out_free;
	logic differ, clear_sets;
	logic signed [TOT_W:0] sum;
	logic signed [TOT_W-1:0] sat;

	// effective vertex count: zero acts as one, clamp to capacity
	always_comb begin
		neff = {1'b0, vcnt_q};
		if (vcnt_q == '0) neff = NEFF_W'(1);
		if (neff > NEFF_W'(MAX_VERTICES)) neff = NEFF_W'(MAX_VERTICES);
	end

	assign key = '{src: edge_source, dst: edge_destination, wt: edge_weight};
	assign in_ready = (state_q == ST_LOAD);
	assign in_xfer  = in_valid && in_ready;
	assign store_ok = ({2'b0, edge_source} < neff) && ({2'b0, edge_destination} < neff)
		&& (count_q < CW'(MAX_EDGES));
	assign ins = in_xfer && store_ok;

	// scan control
	assign done     = (scan_q == count_q) || ((acc_q + NEFF_W'(1)) >= neff);
	assign out_free = !out_valid || out_ready;
	assign accept   = differ && (state_q == ST_SCAN) && !done;
	assign shift    = (state_q == ST_SCAN) && !done && (!accept || !pend_v_q || out_free);
	assign clear_sets = (state_q == ST_FLUSH) && out_free;

	// sorting cells
	for (genvar g = 0; g < MAX_EDGES; g++) begin : g_cell
		kmst_cell u_cell (
			.clk    (clk),
			.ins    (ins),
			.shift  (shift),
			.occ    (CW'(g) < count_q),
			.key    (key),
			.left   ((g == 0) ? key : cur[(g == 0) ? 0 : g-1]),
			.left_gt((g == 0) ? 1'b0 : gtv[(g == 0) ? 0 : g-1]),
			.right  ((g == MAX_EDGES-1) ? cur[g] : cur[(g == MAX_EDGES-1) ? g : g+1]),
			.cur    (cur[g]),
			.gt     (gtv[g])
		);
	end

	kmst_sets #(.MAX_VERTICES(MAX_VERTICES)) u_sets (
		.clk   (clk),
		.arst_n(arst_n),
		.clear (clear_sets),
		.merge (accept && shift),
		.src   (cur[0].src),
		.dst   (cur[0].dst),
		.differ(differ)
	);

	// saturating running total
	always_comb begin
		sum = {total_q[TOT_W-1], total_q} + (TOT_W+1)'(cur[0].wt);
		if (sum > TOTAL_MAX) sat = TOTAL_MAX[TOT_W-1:0];
		else if (sum < TOTAL_MIN) sat = TOTAL_MIN[TOT_W-1:0];
		else sat = sum[TOT_W-1:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:  if (in_xfer && last_edge) state_d = ST_SCAN;
			ST_SCAN:  if (done) state_d = ST_FLUSH;
			ST_FLUSH: if (out_free) state_d = ST_LOAD;
			default:  state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q   <= VCNT_W'(32);
			count_q  <= '0;
			scan_q   <= '0;
			acc_q    <= '0;
			drop_q   <= 1'b0;
			pend_v_q <= 1'b0;
			total_q  <= '0;
		end else begin
			if (cfg_we) vcnt_q <= cfg_wdata;
			if (ins) count_q <= count_q + CW'(1);
			if (in_xfer && !store_ok) drop_q <= 1'b1;
			if (shift) begin
				scan_q <= scan_q + CW'(1);
				if (accept) begin
					acc_q    <= acc_q + NEFF_W'(1);
					pend_v_q <= 1'b1;
					total_q  <= sat;
				end
			end
			if (clear_sets) begin
				count_q  <= '0;
				scan_q   <= '0;
				acc_q    <= '0;
				drop_q   <= 1'b0;
				pend_v_q <= 1'b0;
				total_q  <= '0;
			end
		end
	end

	// pending accepted edge, held until the next accept or the flush
	always_ff @(posedge clk) begin
		if (shift && accept) begin
			pend_q     <= cur[0];
			pend_tot_q <= sat;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if ((shift && accept && pend_v_q) || clear_sets) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (shift && accept && pend_v_q) begin
			tree_source      <= pend_q.src;
			tree_destination <= pend_q.dst;
			tree_weight      <= pend_q.wt;
			edge_valid       <= 1'b1;
			running_total    <= pend_tot_q;
			dropped_flag     <= drop_q;
			last_result      <= 1'b0;
		end else if (clear_sets) begin
			tree_source      <= pend_v_q ? pend_q.src : '0;
			tree_destination <= pend_v_q ? pend_q.dst : '0;
			tree_weight      <= pend_v_q ? pend_q.wt : '0;
			edge_valid       <= pend_v_q;
			running_total    <= pend_v_q ? pend_tot_q : '0;
			dropped_flag     <= drop_q;
			last_result      <= 1'b1;
		end
	end

	a_load_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> !pend_v_q) else $error("pending edge while loading");
	a_acc_le_scan: assert property (@(posedge clk) disable iff (!arst_n)
		({{(CW > NEFF_W ? CW-NEFF_W : 0){1'b0}}, acc_q} <= scan_q + CW'(0)) || (CW < NEFF_W))
		else $error("more accepts than scanned edges");
	a_scan_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		scan_q <= count_q) else $error("scan ran past stored edges");

endmodule
`default_nettype wire

/* src/kmst_cell.sv */
`default_nettype none
module kmst_cell (
	input  wire  logic           clk,
	input  wire  logic           ins,
	input  wire  logic           shift,
	input  wire  logic           occ,
	input  wire  kmst_pkg::edge_t key,
	input  wire  kmst_pkg::edge_t left,
	input  wire  logic           left_gt,
	input  wire  kmst_pkg::edge_t right,
	output       kmst_pkg::edge_t cur,
	output       logic           gt
);
	import kmst_pkg::*;

	edge_t edge_q;

	// empty cells sort as larger than any key; equal weights stay ahead
	assign gt  = !occ || (edge_q.wt > key.wt);
	assign cur = edge_q;

	// insert: make room by taking the left neighbor, or take the key at the boundary
	always_ff @(posedge clk) begin
		if (ins && gt) begin
			edge_q <= left_gt ? left : key;
		end else if (shift) begin
			edge_q <= right;
		end
	end

endmodule
`default_nettype wire

/* src/kmst_sets.sv */
`default_nettype none
module kmst_sets #(
	parameter int MAX_VERTICES = 32
) (
	input  wire  logic                          clk,
	input  wire  logic                          arst_n,
	input  wire  logic                          clear,
	input  wire  logic                          merge,
	input  wire  logic [kmst_pkg::VTX_W-1:0]    src,
	input  wire  logic [kmst_pkg::VTX_W-1:0]    dst,
	output       logic                          differ
);
	import kmst_pkg::*;

	localparam int LW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

	logic [LW-1:0] lab_q [MAX_VERTICES];
	logic [LW-1:0] la, lb;

	// look up the component label of both endpoints
	always_comb begin
		la = '0;
		lb = '0;
		for (int i = 0; i < MAX_VERTICES; i++) begin
			if (i == int'(src)) la = lab_q[i];
			if (i == int'(dst)) lb = lab_q[i];
		end
	end

	assign differ = (la != lb);

	// each vertex cell relabels itself when its component is joined
	for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_lab
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				lab_q[g] <= LW'(g);
			end else if (clear) begin
				lab_q[g] <= LW'(g);
			end else if (merge && lab_q[g] == lb) begin
				lab_q[g] <= la;
			end
		end
	end

endmodule
`default_nettype wire
